FILE: rtl/core/sgh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgh_pkg;

  localparam int MODE_W = 3;
  localparam int REJ_W  = 3;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 16;
  localparam int ID_W   = 32;
  localparam int SEQ_W  = 16;
  localparam int WIN_W  = 8;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [MODE_W-1:0] MODE_BOOT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACCEPTED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READY    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ARMED    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACTIVE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RECOVERY = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd6;

  localparam logic [REJ_W-1:0] REJ_NONE       = 3'd0;
  localparam logic [REJ_W-1:0] REJ_FAULT      = 3'd1;
  localparam logic [REJ_W-1:0] REJ_NOT_FRESH  = 3'd2;
  localparam logic [REJ_W-1:0] REJ_MISMATCH   = 3'd3;
  localparam logic [REJ_W-1:0] REJ_SEQUENCE   = 3'd4;
  localparam logic [REJ_W-1:0] REJ_UNSAFE     = 3'd5;
  localparam logic [REJ_W-1:0] REJ_TRANSITION = 3'd6;

  localparam logic [KIND_W-1:0] KIND_ANNOUNCE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SYNC     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COMMIT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACTIVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABORT    = 3'd4;

  localparam logic [IDX_W-1:0] REG_ARM_DELAY     = 2'd0;
  localparam logic [IDX_W-1:0] REG_DROP          = 2'd1;
  localparam logic [IDX_W-1:0] REG_RECOVER_DELAY = 2'd2;

  localparam logic [CFG_W-1:0] ARM_DELAY_RESET     = 16'd100;
  localparam logic [CFG_W-1:0] DROP_RESET          = 16'd500;
  localparam logic [CFG_W-1:0] RECOVER_DELAY_RESET = 16'd1000;

  localparam logic [WIN_W-1:0] SEQ_WINDOW_MAX = 8'd127;

  typedef struct packed {
    logic              command;
    logic [KIND_W-1:0] request_kind;
    logic [ID_W-1:0]   session_ident;
    logic [SEQ_W-1:0]  sequence_number;
    logic              link_fresh;
    logic              arm_permit;
    logic              hard_fault;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [MODE_W-1:0] gate_state;
    logic [REJ_W-1:0]  reject_code;
    logic              control_enabled;
    logic              requires_failsafe;
  } result_t;

  typedef struct packed {
    logic [MODE_W-1:0] gate_mode;
    logic [REJ_W-1:0]  last_reject;
    logic [ID_W-1:0]   current_session;
    logic [SEQ_W-1:0]  last_seq;
    logic              seq_seen;
    logic              was_active;
    logic [CNT_W-1:0]  stale_count;
    logic [CNT_W-1:0]  arm_count;
    logic [CNT_W-1:0]  recover_count;
  } gate_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] arm_delay_ticks;
    logic [CFG_W-1:0] drop_ticks;
    logic [CFG_W-1:0] recover_delay_ticks;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/sgh_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module sgh_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [sgh_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [sgh_pkg::CFG_W-1:0]     cfg_data,
  output sgh_pkg::cfg_t                      cfg
);

  sgh_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.arm_delay_ticks     <= sgh_pkg::ARM_DELAY_RESET;
      regs.drop_ticks          <= sgh_pkg::DROP_RESET;
      regs.recover_delay_ticks <= sgh_pkg::RECOVER_DELAY_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        sgh_pkg::REG_ARM_DELAY:     regs.arm_delay_ticks     <= cfg_data;
        sgh_pkg::REG_DROP:          regs.drop_ticks          <= cfg_data;
        sgh_pkg::REG_RECOVER_DELAY: regs.recover_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

FILE: rtl/core/sgh_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sgh_step (
  input  wire sgh_pkg::gate_state_t state,
  input  wire sgh_pkg::cfg_t        cfg,
  input  wire sgh_pkg::item_t       item,
  output sgh_pkg::gate_state_t      state_next,
  output sgh_pkg::result_t          result
);

  function automatic logic kind_matches(input logic [sgh_pkg::KIND_W-1:0] kind,
                                        input logic [sgh_pkg::MODE_W-1:0] mode);
    kind_matches = (kind == sgh_pkg::KIND_ANNOUNCE && mode == sgh_pkg::MODE_ACCEPTED) ||
                   (kind == sgh_pkg::KIND_SYNC && mode == sgh_pkg::MODE_READY) ||
                   (kind == sgh_pkg::KIND_COMMIT && mode == sgh_pkg::MODE_ARMED) ||
                   ((kind == sgh_pkg::KIND_COMMIT || kind == sgh_pkg::KIND_ACTIVE) &&
                    mode == sgh_pkg::MODE_ACTIVE);
  endfunction

  sgh_pkg::gate_state_t s;
  logic                      acc;
  logic                      ok;
  logic                      fresh;
  logic                      safe;
  logic                      id_match;
  logic                      seq_equal;
  logic                      in_window;
  logic [sgh_pkg::WIN_W-1:0] seq_diff;

  // tick never touches session, sequence or seen flag
  assign fresh     = item.link_fresh;
  assign safe      = item.arm_permit;
  assign id_match  = item.session_ident == state.current_session;
  assign seq_equal = item.sequence_number == state.last_seq;
  assign seq_diff  = item.sequence_number[sgh_pkg::WIN_W-1:0] -
                     state.last_seq[sgh_pkg::WIN_W-1:0];
  assign in_window = !state.seq_seen ||
                     (seq_diff != '0 && seq_diff <= sgh_pkg::SEQ_WINDOW_MAX);

  always_comb begin
    s   = state;
    acc = 1'b0;
    ok  = 1'b0;

    // tick
    if (item.hard_fault) begin
      s.gate_mode     = sgh_pkg::MODE_FAULT;
      s.last_reject   = sgh_pkg::REJ_FAULT;
      s.stale_count   = '0;
      s.arm_count     = '0;
      s.recover_count = '0;
    end else begin
      unique case (state.gate_mode)
        sgh_pkg::MODE_READY: begin
          if (fresh && safe) begin
            if (s.arm_count < cfg.arm_delay_ticks) s.arm_count = s.arm_count + 16'd1;
            if (s.arm_count >= cfg.arm_delay_ticks) begin
              s.gate_mode = sgh_pkg::MODE_ARMED;
              s.arm_count = '0;
            end
          end else begin
            s.arm_count = '0;
          end
          s.stale_count   = '0;
          s.recover_count = '0;
        end
        sgh_pkg::MODE_ARMED: begin
          if (fresh && safe) begin
            s.gate_mode     = sgh_pkg::MODE_ACTIVE;
            s.was_active    = 1'b1;
            s.stale_count   = '0;
            s.arm_count     = '0;
            s.recover_count = '0;
          end
        end
        sgh_pkg::MODE_ACTIVE: begin
          if (fresh) begin
            s.stale_count = '0;
          end else begin
            if (s.stale_count < cfg.drop_ticks) s.stale_count = s.stale_count + 16'd1;
            if (s.stale_count >= cfg.drop_ticks) begin
              s.gate_mode   = sgh_pkg::MODE_RECOVERY;
              s.last_reject = sgh_pkg::REJ_NOT_FRESH;
              s.stale_count = '0;
            end
          end
          s.arm_count     = '0;
          s.recover_count = '0;
        end
        sgh_pkg::MODE_RECOVERY: begin
          if (fresh && safe) begin
            if (s.recover_count < cfg.recover_delay_ticks) begin
              s.recover_count = s.recover_count + 16'd1;
            end
            if (s.recover_count >= cfg.recover_delay_ticks) begin
              s.gate_mode     = sgh_pkg::MODE_ACCEPTED;
              s.last_reject   = sgh_pkg::REJ_NONE;
              s.stale_count   = '0;
              s.arm_count     = '0;
              s.recover_count = '0;
            end
          end else begin
            s.recover_count = '0;
          end
        end
        default: begin
          s.stale_count   = '0;
          s.arm_count     = '0;
          s.recover_count = '0;
        end
      endcase
    end

    // request
    if (item.command) begin
      if (s.gate_mode == sgh_pkg::MODE_FAULT) begin
        acc = 1'b0;
      end else if (item.request_kind == sgh_pkg::KIND_ABORT) begin
        s             = '0;
        s.gate_mode   = sgh_pkg::MODE_BOOT;
        s.last_reject = sgh_pkg::REJ_NONE;
        acc           = 1'b1;
      end else if (item.session_ident == '0) begin
        s.last_reject = sgh_pkg::REJ_MISMATCH;
      end else if (item.request_kind == sgh_pkg::KIND_ANNOUNCE) begin
        acc = 1'b1;
        if (!(s.seq_seen && id_match && seq_equal &&
              s.gate_mode == sgh_pkg::MODE_ACCEPTED)) begin
          s.current_session = item.session_ident;
          s.last_seq        = item.sequence_number;
          s.seq_seen        = 1'b1;
          s.was_active      = 1'b0;
          s.stale_count     = '0;
          s.arm_count       = '0;
          s.recover_count   = '0;
          s.gate_mode       = sgh_pkg::MODE_ACCEPTED;
          s.last_reject     = sgh_pkg::REJ_NONE;
        end
      end else if (s.seq_seen && id_match && seq_equal &&
                   kind_matches(item.request_kind, s.gate_mode)) begin
        acc = 1'b1;
      end else if (!id_match) begin
        s.last_reject = sgh_pkg::REJ_MISMATCH;
      end else if (!in_window) begin
        s.last_reject = sgh_pkg::REJ_SEQUENCE;
      end else begin
        if (kind_matches(item.request_kind, s.gate_mode)) begin
          ok = 1'b1;
        end else if (s.gate_mode == sgh_pkg::MODE_ACCEPTED &&
                     item.request_kind == sgh_pkg::KIND_SYNC) begin
          if (!fresh) begin
            s.last_reject = sgh_pkg::REJ_NOT_FRESH;
          end else begin
            s.gate_mode = sgh_pkg::MODE_READY;
            ok          = 1'b1;
          end
        end else if ((s.gate_mode == sgh_pkg::MODE_ARMED ||
                      s.gate_mode == sgh_pkg::MODE_ACTIVE) &&
                     item.request_kind == sgh_pkg::KIND_COMMIT) begin
          if (!fresh) begin
            s.last_reject = sgh_pkg::REJ_NOT_FRESH;
          end else if (!safe) begin
            s.last_reject = sgh_pkg::REJ_UNSAFE;
          end else begin
            s.gate_mode     = sgh_pkg::MODE_ACTIVE;
            s.was_active    = 1'b1;
            s.stale_count   = '0;
            s.arm_count     = '0;
            s.recover_count = '0;
            ok              = 1'b1;
          end
        end else begin
          s.last_reject = sgh_pkg::REJ_TRANSITION;
        end
        if (ok) begin
          s.last_seq    = item.sequence_number;
          s.seq_seen    = 1'b1;
          s.last_reject = sgh_pkg::REJ_NONE;
          acc           = 1'b1;
        end
      end
    end
  end

  assign state_next                = s;
  assign result.accepted           = acc;
  assign result.gate_state         = s.gate_mode;
  assign result.reject_code        = s.last_reject;
  assign result.control_enabled    = s.gate_mode == sgh_pkg::MODE_ACTIVE;
  assign result.requires_failsafe  = s.was_active && (s.gate_mode != sgh_pkg::MODE_ACTIVE);

endmodule

`default_nettype wire

FILE: rtl/core/session_gate_handshake_fsm_unit.sv
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_stall    | sgh_pkg::item_t
// result   | out       | result_valid / result_stall| sgh_pkg::result_t
// cfg      | in        | cfg_write_en               | cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; result_valid rises
// after an item passes the input register, one state update, result register.
// Synchronous rst clears gate state, both valid bits and the config registers
// to their defaults.
// A stalled result holds the input register; item_stall follows result_stall
// only while both registers are occupied.
`timescale 1ns / 1ps
`default_nettype none

module session_gate_handshake_fsm_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire sgh_pkg::item_t            item,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output sgh_pkg::result_t               result,
  input  wire logic                      cfg_write_en,
  input  wire logic [sgh_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [sgh_pkg::CFG_W-1:0] cfg_data
);

  sgh_pkg::cfg_t        cfg;
  sgh_pkg::item_t       held;
  logic                 held_valid;
  sgh_pkg::gate_state_t state;
  sgh_pkg::gate_state_t state_next;
  sgh_pkg::result_t     step_result;
  logic                 advance;
  logic                 fire;

  sgh_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  sgh_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (held),
    .state_next (state_next),
    .result     (step_result)
  );

  assign advance    = !result_valid || !result_stall;
  assign fire       = held_valid && advance;
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{gate_mode: sgh_pkg::MODE_BOOT, last_reject: sgh_pkg::REJ_NONE,
                 default: '0};
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= step_result;
    end
  end

`ifndef SYNTH
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (state.gate_mode == sgh_pkg::MODE_FAULT) |=> (state.gate_mode == sgh_pkg::MODE_FAULT))
    else $error("fault lock left without reset");

  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state))
    else $error("gate state changed without a transfer");

  a_result_tracks: assert property (@(posedge clk) disable iff (rst)
    fire |=> (result_valid && result.gate_state == state.gate_mode))
    else $error("result gate_state differs from stored mode");
`endif

endmodule

`default_nettype wire
